FILE: rtl/pgcc_pkg.sv
// Shared types and codes for the prerequisite graph cycle check block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pgcc_pkg;
   localparam int NODE_W = 8;
   localparam int CFG_W = 9;

   typedef enum logic [2:0] {
      CMD_CLEAR = 3'd0,
      CMD_ADD   = 3'd1,
      CMD_CHECK = 3'd2,
      CMD_QUERY = 3'd3,
      CMD_SET   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_EXISTS  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_ADD_RD,
      S_ADD_CHK,
      S_QRY_RD,
      S_QRY_CHK,
      S_QRY_DONE,
      S_CLR_MARKS,
      S_ROOT_RD,
      S_ROOT_CHK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_MARK_CHK,
      S_POP_WAIT,
      S_POST
   } state_type;
endpackage
`default_nettype wire

FILE: rtl/pgcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pgcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/prerequisite_graph_cycle_check_core.sv
// Top level of the prerequisite graph cycle check block.
// Depends on pgcc_pkg and pgcc_ram (edge, walk mark, done mark and stack memories).
//
//   channel | ports                                   | transfer when
//   req     | req_command/source_node/target_node/... | req_valid & req_ready
//   rsp     | rsp_status, rsp_answer                  | rsp_valid & rsp_ready
//   csr     | csr_write_enable, csr_write_data        | csr_write_enable
//
// Clear, set and bad arguments go straight to the response. Add and query read
// the edge RAM up to once per stored edge; query also reads the done mark of the
// source of each matching edge. Check first clears every walk mark, then walks
// the edges depth first from each unmarked root node, reading edge and mark RAMs.
// After reset, every done mark is cleared while req_ready stays low.
// A result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module prerequisite_graph_cycle_check_core #(
   parameter int MAX_NODES = 256,
   parameter int EDGE_CAPACITY = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [2:0]                   req_command,
   input  wire logic [pgcc_pkg::NODE_W-1:0]  req_source_node,
   input  wire logic [pgcc_pkg::NODE_W-1:0]  req_target_node,
   input  wire logic                         req_done_flag,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_answer,
   input  wire logic                         csr_write_enable,
   input  wire logic [pgcc_pkg::CFG_W-1:0]   csr_write_data
);
   localparam int NW = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
   localparam int EW = EDGE_CAPACITY > 1 ? $clog2(EDGE_CAPACITY) : 1;
   localparam int KW = $clog2(EDGE_CAPACITY + 1);
   localparam int SPW = $clog2(MAX_NODES + 1);
   localparam int NDW = pgcc_pkg::NODE_W;
   localparam int CW = pgcc_pkg::CFG_W;
   localparam int FW = NDW + KW;
   localparam logic [1:0] MARK_NONE = 2'd0;
   localparam logic [1:0] MARK_PATH = 2'd1;
   localparam logic [1:0] MARK_DONE = 2'd2;

   pgcc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [KW-1:0]  used_ff, used_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [NW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  root_ff, root_in;
   logic [NDW-1:0] top_ff, top_in;
   logic [NDW-1:0] dest_ff, dest_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [NDW-1:0] src_ff, src_in;
   logic [NDW-1:0] dst_ff, dst_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic           res_answer_ff, res_answer_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic           rsp_answer_ff, rsp_answer_in;

   logic [CW-1:0] lim;
   logic [KW-1:0] k_next;

   logic           e_we, e_re;
   logic [EW-1:0]  e_waddr, e_raddr;
   logic [2*NDW-1:0] e_wdata, e_rdata;
   logic           m_we, m_re;
   logic [NW-1:0]  m_waddr, m_raddr;
   logic [1:0]     m_wdata, m_rdata;
   logic           d_we, d_re;
   logic [NW-1:0]  d_waddr, d_raddr;
   logic [0:0]     d_wdata, d_rdata;
   logic           s_we, s_re;
   logic [NW-1:0]  s_waddr, s_raddr;
   logic [FW-1:0]  s_wdata, s_rdata;

   logic [NDW-1:0] e_from, e_to;

   assign e_from = e_rdata[2*NDW-1:NDW];
   assign e_to = e_rdata[NDW-1:0];
   assign lim = (count_ff > CW'(MAX_NODES)) ? CW'(MAX_NODES) : count_ff;
   assign k_next = KW'(k_ff + 1'b1);

   pgcc_ram #(.WIDTH(2*NDW), .DEPTH(EDGE_CAPACITY)) u_edge_ram (
      .clock(clock), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
      .rd_en(e_re), .rd_addr(e_raddr), .rd_data(e_rdata)
   );
   pgcc_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_mark_ram (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_en(m_re), .rd_addr(m_raddr), .rd_data(m_rdata)
   );
   pgcc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_done_ram (
      .clock(clock), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
      .rd_en(d_re), .rd_addr(d_raddr), .rd_data(d_rdata)
   );
   pgcc_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_stack_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_en(s_re), .rd_addr(s_raddr), .rd_data(s_rdata)
   );

   // next state and register updates
   always_comb begin
      state_in = state_ff;
      count_in = csr_write_enable ? csr_write_data : count_ff;
      used_in = used_ff;
      k_in = k_ff;
      idx_in = idx_ff;
      root_in = root_ff;
      top_in = top_ff;
      dest_in = dest_ff;
      sp_in = sp_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      res_status_in = res_status_ff;
      res_answer_in = res_answer_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_answer_in = rsp_answer_ff;
      case (state_ff)
         pgcc_pkg::S_INIT: begin
            idx_in = NW'(idx_ff + 1'b1);
            if (idx_ff == NW'(MAX_NODES - 1)) begin
               state_in = pgcc_pkg::S_IDLE;
            end
         end
         pgcc_pkg::S_IDLE: begin
            if (req_valid) begin
               src_in = req_source_node;
               dst_in = req_target_node;
               k_in = '0;
               idx_in = '0;
               res_status_in = pgcc_pkg::ST_OK;
               res_answer_in = 1'b0;
               state_in = pgcc_pkg::S_POST;
               case (req_command)
                  pgcc_pkg::CMD_CLEAR: begin
                     used_in = '0;
                  end
                  pgcc_pkg::CMD_ADD: begin
                     if ({1'b0, req_source_node} >= lim || {1'b0, req_target_node} >= lim
                         || req_source_node == req_target_node) begin
                        res_status_in = pgcc_pkg::ST_INVALID;
                     end else begin
                        state_in = pgcc_pkg::S_ADD_RD;
                     end
                  end
                  pgcc_pkg::CMD_CHECK: begin
                     state_in = pgcc_pkg::S_CLR_MARKS;
                  end
                  pgcc_pkg::CMD_QUERY: begin
                     if ({1'b0, req_target_node} >= lim) begin
                        res_status_in = pgcc_pkg::ST_INVALID;
                     end else begin
                        state_in = pgcc_pkg::S_QRY_RD;
                     end
                  end
                  pgcc_pkg::CMD_SET: begin
                     if ({1'b0, req_target_node} >= lim) begin
                        res_status_in = pgcc_pkg::ST_INVALID;
                     end
                  end
                  default: begin
                     res_status_in = pgcc_pkg::ST_INVALID;
                  end
               endcase
            end
         end
         pgcc_pkg::S_ADD_RD: begin
            if (k_ff >= used_ff) begin
               state_in = pgcc_pkg::S_POST;
               if (used_ff >= KW'(EDGE_CAPACITY)) begin
                  res_status_in = pgcc_pkg::ST_FULL;
               end else begin
                  used_in = KW'(used_ff + 1'b1);
               end
            end else begin
               state_in = pgcc_pkg::S_ADD_CHK;
            end
         end
         pgcc_pkg::S_ADD_CHK: begin
            if (e_from == src_ff && e_to == dst_ff) begin
               res_status_in = pgcc_pkg::ST_EXISTS;
               state_in = pgcc_pkg::S_POST;
            end else begin
               k_in = k_next;
               state_in = pgcc_pkg::S_ADD_RD;
            end
         end
         pgcc_pkg::S_QRY_RD: begin
            if (k_ff >= used_ff) begin
               res_answer_in = 1'b1;
               state_in = pgcc_pkg::S_POST;
            end else begin
               state_in = pgcc_pkg::S_QRY_CHK;
            end
         end
         pgcc_pkg::S_QRY_CHK: begin
            if (e_to == dst_ff) begin
               state_in = pgcc_pkg::S_QRY_DONE;
            end else begin
               k_in = k_next;
               state_in = pgcc_pkg::S_QRY_RD;
            end
         end
         pgcc_pkg::S_QRY_DONE: begin
            if (d_rdata == 1'b0) begin
               state_in = pgcc_pkg::S_POST;
            end else begin
               k_in = k_next;
               state_in = pgcc_pkg::S_QRY_RD;
            end
         end
         pgcc_pkg::S_CLR_MARKS: begin
            idx_in = NW'(idx_ff + 1'b1);
            if (idx_ff == NW'(MAX_NODES - 1)) begin
               root_in = '0;
               state_in = pgcc_pkg::S_ROOT_RD;
            end
         end
         pgcc_pkg::S_ROOT_RD: begin
            if (root_ff >= lim) begin
               state_in = pgcc_pkg::S_POST;
            end else begin
               state_in = pgcc_pkg::S_ROOT_CHK;
            end
         end
         pgcc_pkg::S_ROOT_CHK: begin
            if (m_rdata != MARK_NONE) begin
               root_in = CW'(root_ff + 1'b1);
               state_in = pgcc_pkg::S_ROOT_RD;
            end else begin
               top_in = root_ff[NDW-1:0];
               k_in = '0;
               sp_in = '0;
               state_in = pgcc_pkg::S_SCAN_RD;
            end
         end
         pgcc_pkg::S_SCAN_RD: begin
            if (k_ff >= used_ff) begin
               if (sp_ff == '0) begin
                  root_in = CW'(root_ff + 1'b1);
                  state_in = pgcc_pkg::S_ROOT_RD;
               end else begin
                  state_in = pgcc_pkg::S_POP_WAIT;
               end
            end else begin
               state_in = pgcc_pkg::S_SCAN_CHK;
            end
         end
         pgcc_pkg::S_SCAN_CHK: begin
            if (e_from == top_ff) begin
               dest_in = e_to;
               state_in = pgcc_pkg::S_MARK_CHK;
            end else begin
               k_in = k_next;
               state_in = pgcc_pkg::S_SCAN_RD;
            end
         end
         pgcc_pkg::S_MARK_CHK: begin
            if (m_rdata == MARK_PATH) begin
               res_answer_in = 1'b1;
               state_in = pgcc_pkg::S_POST;
            end else if (m_rdata == MARK_NONE) begin
               sp_in = SPW'(sp_ff + 1'b1);
               top_in = dest_ff;
               k_in = '0;
               state_in = pgcc_pkg::S_SCAN_RD;
            end else begin
               k_in = k_next;
               state_in = pgcc_pkg::S_SCAN_RD;
            end
         end
         pgcc_pkg::S_POP_WAIT: begin
            top_in = s_rdata[FW-1:KW];
            k_in = s_rdata[KW-1:0];
            sp_in = SPW'(sp_ff - 1'b1);
            state_in = pgcc_pkg::S_SCAN_RD;
         end
         pgcc_pkg::S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_answer_in = res_answer_ff;
               state_in = pgcc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pgcc_pkg::S_IDLE;
         end
      endcase
   end

   // memory controls
   always_comb begin
      e_we = 1'b0;
      e_waddr = used_ff[EW-1:0];
      e_wdata = {src_ff, dst_ff};
      e_re = 1'b0;
      e_raddr = k_ff[EW-1:0];
      m_we = 1'b0;
      m_waddr = idx_ff;
      m_wdata = MARK_NONE;
      m_re = 1'b0;
      m_raddr = root_ff[NW-1:0];
      d_we = 1'b0;
      d_waddr = idx_ff;
      d_wdata = 1'b0;
      d_re = 1'b0;
      d_raddr = e_from[NW-1:0];
      s_we = 1'b0;
      s_waddr = sp_ff[NW-1:0];
      s_wdata = {top_ff, k_next};
      s_re = 1'b0;
      s_raddr = NW'(sp_ff - 1'b1);
      case (state_ff)
         pgcc_pkg::S_INIT: begin
            d_we = 1'b1;
         end
         pgcc_pkg::S_IDLE: begin
            if (req_valid && req_command == pgcc_pkg::CMD_SET
                && {1'b0, req_target_node} < lim) begin
               d_we = 1'b1;
               d_waddr = req_target_node[NW-1:0];
               d_wdata = req_done_flag;
            end
         end
         pgcc_pkg::S_ADD_RD: begin
            if (k_ff >= used_ff) begin
               e_we = used_ff < KW'(EDGE_CAPACITY);
            end else begin
               e_re = 1'b1;
            end
         end
         pgcc_pkg::S_QRY_RD: begin
            e_re = k_ff < used_ff;
         end
         pgcc_pkg::S_QRY_CHK: begin
            d_re = 1'b1;
         end
         pgcc_pkg::S_CLR_MARKS: begin
            m_we = 1'b1;
         end
         pgcc_pkg::S_ROOT_RD: begin
            m_re = 1'b1;
         end
         pgcc_pkg::S_ROOT_CHK: begin
            if (m_rdata == MARK_NONE) begin
               m_we = 1'b1;
               m_waddr = root_ff[NW-1:0];
               m_wdata = MARK_PATH;
            end
         end
         pgcc_pkg::S_SCAN_RD: begin
            if (k_ff >= used_ff) begin
               m_we = 1'b1;
               m_waddr = top_ff[NW-1:0];
               m_wdata = MARK_DONE;
               s_re = sp_ff != '0;
            end else begin
               e_re = 1'b1;
            end
         end
         pgcc_pkg::S_SCAN_CHK: begin
            m_re = 1'b1;
            m_raddr = e_to[NW-1:0];
         end
         pgcc_pkg::S_MARK_CHK: begin
            if (m_rdata == MARK_NONE) begin
               m_we = 1'b1;
               m_waddr = dest_ff[NW-1:0];
               m_wdata = MARK_PATH;
               s_we = 1'b1;
            end
         end
         default: begin
            e_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgcc_pkg::S_INIT;
         count_ff <= '0;
         used_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         used_ff <= used_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in;
      root_ff <= root_in;
      top_ff <= top_in;
      dest_ff <= dest_in;
      sp_ff <= sp_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      res_status_ff <= res_status_in;
      res_answer_ff <= res_answer_in;
      rsp_status_ff <= rsp_status_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   assign req_ready = (state_ff == pgcc_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_answer = rsp_answer_ff;
endmodule
`default_nettype wire

FILE: rtl/pgcc_checker.sv
// Port-level checks for prerequisite_graph_cycle_check_core.
// Depends on pgcc_pkg; bound to the top level below.
`timescale 1ns / 1ps
`default_nettype none
module pgcc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_answer
);
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req_ready during done mark clear");
   a_err_answer: assert property (@(posedge clock)
      rsp_valid && rsp_status != pgcc_pkg::ST_OK |-> !rsp_answer)
      else $error("answer set on error");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_answer))
      else $error("stalled transfer changed");
endmodule

bind prerequisite_graph_cycle_check_core pgcc_checker u_pgcc_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_status(rsp_status), .rsp_answer(rsp_answer)
);
`default_nettype wire

FILE: sim/tb_prerequisite_graph_cycle_check_core.sv
// Self-checking bench for prerequisite_graph_cycle_check_core: a local edge-table and
// done-mark model predicts each response, checked in order against the DUT outputs.
// Depends on pgcc_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_prerequisite_graph_cycle_check_core;
   localparam int NODES = 256;
   localparam int EDGES = 256;
   localparam logic [2:0] CMD_BAD_LO = 3'd5;
   localparam logic [2:0] CMD_BAD_MID = 3'd6;
   localparam logic [2:0] CMD_BAD_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_command = '0;
   logic [pgcc_pkg::NODE_W-1:0] req_source_node = '0;
   logic [pgcc_pkg::NODE_W-1:0] req_target_node = '0;
   logic req_done_flag = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_answer;
   logic csr_write_enable = 1'b0;
   logic [pgcc_pkg::CFG_W-1:0] csr_write_data = '0;

   prerequisite_graph_cycle_check_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_source_node(req_source_node),
      .req_target_node(req_target_node), .req_done_flag(req_done_flag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_answer(rsp_answer),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   typedef struct packed {
      logic [1:0] status;
      logic       answer;
   } reply_type;

   logic [7:0] graph_src [EDGES];
   logic [7:0] graph_dst [EDGES];
   int unsigned graph_count;
   logic done_bits [NODES];
   logic [1:0] visit [NODES];
   logic [7:0] path_node [NODES];
   int unsigned path_next [NODES];
   logic [8:0] active_nodes;
   reply_type pending_replies [$];
   int errors = 0;
   int burst_left = 0;

   function automatic int unsigned live_nodes();
      return (active_nodes > NODES) ? NODES : active_nodes;
   endfunction

   function automatic logic graph_has_cycle();
      int unsigned sp, k;
      logic moved;
      logic [7:0] d;
      for (int i = 0; i < NODES; i++) visit[i] = 2'd0;
      for (int unsigned r = 0; r < live_nodes(); r++) begin
         if (visit[r] != 2'd0) continue;
         visit[r] = 2'd1;
         path_node[0] = r[7:0];
         path_next[0] = 0;
         sp = 1;
         while (sp > 0) begin
            k = path_next[sp-1];
            moved = 1'b0;
            while (k < graph_count) begin
               if (graph_src[k] == path_node[sp-1]) begin
                  d = graph_dst[k];
                  path_next[sp-1] = k + 1;
                  if (visit[d] == 2'd1) return 1'b1;
                  if (visit[d] == 2'd0 && sp < NODES) begin
                     visit[d] = 2'd1;
                     path_node[sp] = d;
                     path_next[sp] = 0;
                     sp++;
                     moved = 1'b1;
                     break;
                  end
               end
               k++;
            end
            if (!moved) begin
               visit[path_node[sp-1]] = 2'd2;
               sp--;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic reply_type predict_reply(logic [2:0] cmd, logic [7:0] src,
                                               logic [7:0] dst, logic flag);
      reply_type r;
      logic blocked;
      r = '0;
      case (cmd)
         pgcc_pkg::CMD_CLEAR: graph_count = 0;
         pgcc_pkg::CMD_ADD: begin
            if (src >= live_nodes() || dst >= live_nodes() || src == dst) begin
               r.status = pgcc_pkg::ST_INVALID;
            end else begin
               for (int unsigned k = 0; k < graph_count; k++)
                  if (graph_src[k] == src && graph_dst[k] == dst)
                     r.status = pgcc_pkg::ST_EXISTS;
               if (r.status == pgcc_pkg::ST_OK && graph_count >= EDGES)
                  r.status = pgcc_pkg::ST_FULL;
               if (r.status == pgcc_pkg::ST_OK) begin
                  graph_src[graph_count] = src;
                  graph_dst[graph_count] = dst;
                  graph_count++;
               end
            end
         end
         pgcc_pkg::CMD_CHECK: r.answer = graph_has_cycle();
         pgcc_pkg::CMD_QUERY: begin
            if (dst >= live_nodes()) begin
               r.status = pgcc_pkg::ST_INVALID;
            end else begin
               blocked = 1'b0;
               for (int unsigned k = 0; k < graph_count; k++)
                  if (graph_dst[k] == dst && !done_bits[graph_src[k]]) blocked = 1'b1;
               r.answer = ~blocked;
            end
         end
         pgcc_pkg::CMD_SET: begin
            if (dst >= live_nodes()) r.status = pgcc_pkg::ST_INVALID;
            else done_bits[dst] = flag;
         end
         default: r.status = pgcc_pkg::ST_INVALID;
      endcase
      return r;
   endfunction

   // Sender: bursts with random gaps; valid held until transfer.
   task automatic send_request(logic [2:0] cmd, logic [7:0] src, logic [7:0] dst,
                               logic flag);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_source_node <= src;
      req_target_node <= dst;
      req_done_flag <= flag;
      pending_replies.push_back(predict_reply(cmd, src, dst, flag));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_node_count(logic [8:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      active_nodes = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver stall pattern: rotating mask with random phases of full readiness.
   logic [15:0] stall_mask = 16'b1011_0111_1101_1110;
   always @(posedge clock) begin
      if (($urandom & 127) == 0) stall_mask <= 16'hFFFF;
      else if (($urandom & 63) == 0) stall_mask <= 16'($urandom);
      else stall_mask <= {stall_mask[14:0], stall_mask[15]};
      rsp_ready <= stall_mask[0] | (($urandom & 3) == 0);
   end

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response status=%0d answer=%0d",
                                       rsp_status, rsp_answer);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status || rsp_answer !== want.answer) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: status exp %0d got %0d, answer exp %0d got %0d",
                           want.status, rsp_status, want.answer, rsp_answer);
            end
         end
      end
   end

   task automatic test_directed();
      write_node_count(9'd4);
      send_request(pgcc_pkg::CMD_QUERY, 8'd0, 8'd3, 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd0, 8'd1, 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd0, 8'd1, 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd2, 8'd2, 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd4, 8'd1, 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd1, 8'd255, 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd1, 8'd2, 1'b0);
      send_request(pgcc_pkg::CMD_CHECK, 8'd0, 8'd0, 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd2, 8'd0, 1'b0);
      send_request(pgcc_pkg::CMD_CHECK, 8'd0, 8'd0, 1'b0);
      send_request(pgcc_pkg::CMD_QUERY, 8'd0, 8'd1, 1'b0);
      send_request(pgcc_pkg::CMD_SET, 8'd0, 8'd0, 1'b1);
      send_request(pgcc_pkg::CMD_QUERY, 8'd0, 8'd1, 1'b0);
      send_request(pgcc_pkg::CMD_SET, 8'd0, 8'd4, 1'b1);
      send_request(pgcc_pkg::CMD_QUERY, 8'd0, 8'd200, 1'b0);
      send_request(CMD_BAD_LO, 8'hFF, 8'hFF, 1'b1);
      send_request(CMD_BAD_MID, 8'd0, 8'd0, 1'b0);
      send_request(CMD_BAD_HI, 8'd0, 8'd0, 1'b0);
      // shrink the node set while edges remain stored
      write_node_count(9'd1);
      send_request(pgcc_pkg::CMD_CHECK, 8'd0, 8'd0, 1'b0);
      send_request(pgcc_pkg::CMD_QUERY, 8'd0, 8'd1, 1'b0);
      send_request(pgcc_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);
      send_request(pgcc_pkg::CMD_CHECK, 8'd0, 8'd0, 1'b0);
      write_node_count(9'd0);
      send_request(pgcc_pkg::CMD_SET, 8'd0, 8'd0, 1'b0);
      send_request(pgcc_pkg::CMD_CHECK, 8'd0, 8'd0, 1'b0);
   endtask

   // Fill the edge table to capacity to hit the full status.
   task automatic test_capacity();
      write_node_count(9'd511);
      send_request(pgcc_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);
      for (int i = 0; i < EDGES; i++)
         send_request(pgcc_pkg::CMD_ADD, i[7:0], 8'(i + 1), 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd3, 8'd9, 1'b0);
      send_request(pgcc_pkg::CMD_ADD, 8'd0, 8'd1, 1'b0);
      send_request(pgcc_pkg::CMD_CHECK, 8'd0, 8'd0, 1'b0);
      send_request(pgcc_pkg::CMD_QUERY, 8'd0, 8'd255, 1'b0);
      send_request(pgcc_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);
   endtask

   task automatic test_random(int phases, int per_phase);
      logic [7:0] hi, s, d;
      logic [2:0] cmd;
      int unsigned pick;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 3))
            0: write_node_count(9'($urandom_range(2, 8)));
            1: write_node_count(9'($urandom_range(9, 40)));
            2: write_node_count(9'd256);
            default: write_node_count(9'($urandom_range(0, 511)));
         endcase
         hi = (active_nodes == 0) ? 8'd0 : 8'(live_nodes() - 1);
         if (active_nodes > 40) hi = 8'($urandom_range(4, 30));
         for (int i = 0; i < per_phase; i++) begin
            pick = $urandom_range(0, 99);
            s = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, hi));
            d = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, hi));
            if (pick < 45) cmd = pgcc_pkg::CMD_ADD;
            else if (pick < 57) cmd = pgcc_pkg::CMD_CHECK;
            else if (pick < 74) cmd = pgcc_pkg::CMD_QUERY;
            else if (pick < 93) cmd = pgcc_pkg::CMD_SET;
            else if (pick < 97) cmd = pgcc_pkg::CMD_CLEAR;
            else cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
            send_request(cmd, s, d, 1'($urandom));
         end
         // hold off until every response is back
         if (p == phases / 2) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) done_bits[i] = 1'b0;
      graph_count = 0;
      active_nodes = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity();
      test_random(14, 83);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
